>>> design/input_auto_repeat_qualifier_assert.svh
// Assertion macros shared by the auto-repeat qualifier modules.
// Included by files that check their own logic; no other dependencies.
`ifndef INPUT_AUTO_REPEAT_QUALIFIER_ASSERT_SVH
`define INPUT_AUTO_REPEAT_QUALIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define IARQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IARQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IARQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IARQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/iarq_pkg.sv
// Shared types and constants for the auto-repeat qualifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package iarq_pkg;

   // Fixed field widths.
   localparam int CHANNEL_W   = 5;
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int PERIOD_W    = 16;
   localparam int DEADZONE_W  = 15;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_BAND     = 2'd2;

   // Configuration reset values.
   localparam logic [PERIOD_W-1:0]   HOLD_DELAY_RESET    = 16'd500;
   localparam logic [PERIOD_W-1:0]   REPEAT_PERIOD_RESET = 16'd100;
   localparam logic [DEADZONE_W-1:0] DEAD_BAND_RESET     = 15'd8000;

   // Axis direction class.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd2
   } dir_type;

   // A classified item as it travels from the front to the back.
   typedef struct packed {
      logic [CHANNEL_W-1:0]       channel;
      logic                       in_range;
      logic                       menu_mode;
      logic                       active;
      logic                       nonzero;
      dir_type                    cls;
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          time_ms;
   } item_type;

   // Repeat timing settings used by the back end.
   typedef struct packed {
      logic [PERIOD_W-1:0] hold_delay;
      logic [PERIOD_W-1:0] repeat_period;
   } timing_type;

endpackage

>>> design/iarq_front.sv
// Front end: checks the channel range and classifies the sample of an item.
// Depends on iarq_pkg.
`timescale 1ns / 1ps

module iarq_front import iarq_pkg::*; #(
   parameter int NUM_BUTTONS  = 15,
   parameter int NUM_CHANNELS = 21
) (
   input  logic [CHANNEL_W-1:0]       req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [TIME_W-1:0]          req_time_ms,
   input  logic                       req_menu_mode,
   input  logic [DEADZONE_W-1:0]      dead_band,
   output item_type                   item
);

   localparam int LIMIT   = (NUM_CHANNELS > NUM_BUTTONS) ? NUM_CHANNELS : NUM_BUTTONS;
   localparam int LIMIT_W = $clog2(LIMIT + 1);
   localparam int CMP_W   = (LIMIT_W > CHANNEL_W) ? LIMIT_W : CHANNEL_W;

   logic [CMP_W-1:0]           channel_ext;
   logic                       is_axis;
   logic signed [SAMPLE_W-1:0] dz_pos;
   logic signed [SAMPLE_W-1:0] dz_neg;
   dir_type                    cls;
   logic                       nonzero;

   // Channel range and kind.
   assign channel_ext = CMP_W'(req_channel);
   assign is_axis     = channel_ext >= CMP_W'(NUM_BUTTONS);

   // Deadzone bounds; the magnitude fits in the sample width.
   assign dz_pos = signed'({1'b0, dead_band});
   assign dz_neg = -dz_pos;

   assign nonzero = |req_sample;

   // Axis class; buttons always classify as DIR_NONE.
   always_comb begin
      cls = DIR_NONE;
      if (is_axis) begin
         if (req_sample > dz_pos) begin
            cls = DIR_POS;
         end else if (req_sample < dz_neg) begin
            cls = DIR_NEG;
         end
      end
   end

   always_comb begin
      item.channel   = req_channel;
      item.in_range  = channel_ext < CMP_W'(NUM_CHANNELS);
      item.menu_mode = req_menu_mode;
      item.active    = is_axis ? (cls != DIR_NONE) : nonzero;
      item.nonzero   = nonzero;
      item.cls       = cls;
      item.sample    = req_sample;
      item.time_ms   = req_time_ms;
   end

endmodule

>>> design/iarq_queue.sv
// Short item queue between the front and the back end.
// Depends on iarq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "input_auto_repeat_qualifier_assert.svh"

module iarq_queue import iarq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `IARQ_ASSERT_IMPLY(a_q_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
   `IARQ_ASSERT_NEXT(a_q_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "push did not grow queue")
   `IARQ_ASSERT_NEXT(a_q_pop_shrinks, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1), "pop did not shrink queue")

endmodule

>>> design/iarq_back.sv
// Back end: per-channel repeat state, firing decision and result register.
// Depends on iarq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "input_auto_repeat_qualifier_assert.svh"

module iarq_back import iarq_pkg::*; #(
   parameter int NUM_CHANNELS = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   output logic                       item_ready,
   input  item_type                   item,
   input  timing_type                 timing,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CHANNEL_W-1:0]       rsp_out_channel,
   output logic                       rsp_fire,
   output logic [1:0]                 rsp_direction,
   output logic signed [SAMPLE_W-1:0] rsp_raw_level
);

   localparam int IDX_W = $clog2(NUM_CHANNELS);
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam int CMP_W = (CNT_W > CHANNEL_W) ? CNT_W : CHANNEL_W;

   // Per-channel state.
   logic              held_ff      [NUM_CHANNELS];
   logic              repeating_ff [NUM_CHANNELS];
   logic [TIME_W-1:0] last_fire_ff [NUM_CHANNELS];

   // Result register.
   logic                       rsp_valid_ff;
   logic [CHANNEL_W-1:0]       rsp_channel_ff;
   logic                       rsp_fire_ff;
   dir_type                    rsp_direction_ff;
   logic signed [SAMPLE_W-1:0] rsp_raw_level_ff;

   logic [CMP_W-1:0]           channel_ext;
   logic [IDX_W-1:0]           idx;
   logic                       pop;
   logic                       cur_held;
   logic                       cur_repeating;
   logic [TIME_W-1:0]          cur_last_fire;
   logic [TIME_W-1:0]          elapsed;
   logic                       state_wr;
   logic                       held_in;
   logic                       repeating_in;
   logic [TIME_W-1:0]          last_fire_in;
   logic                       fire;
   dir_type                    direction;
   logic signed [SAMPLE_W-1:0] raw_level;

   assign channel_ext = CMP_W'(item.channel);
   assign idx         = channel_ext[IDX_W-1:0];
   assign item_ready  = !rsp_valid_ff || rsp_ready;
   assign pop         = item_valid && item_ready;

   assign cur_held      = held_ff[idx];
   assign cur_repeating = repeating_ff[idx];
   assign cur_last_fire = last_fire_ff[idx];
   assign elapsed       = item.time_ms - cur_last_fire;

   // Firing decision and next channel state.
   always_comb begin
      state_wr     = 1'b0;
      held_in      = cur_held;
      repeating_in = cur_repeating;
      last_fire_in = cur_last_fire;
      fire         = 1'b0;
      direction    = DIR_NONE;
      raw_level    = '0;
      if (item.in_range) begin
         state_wr = 1'b1;
         if (!item.menu_mode) begin
            // Pass-through restarts the channel timer.
            fire         = item.nonzero;
            raw_level    = item.sample;
            held_in      = item.nonzero;
            repeating_in = 1'b0;
            last_fire_in = item.time_ms;
         end else if (item.active) begin
            if (!cur_held) begin
               fire         = 1'b1;
               repeating_in = 1'b0;
            end else if (cur_repeating) begin
               fire = elapsed >= TIME_W'(timing.repeat_period);
            end else if (elapsed >= TIME_W'(timing.hold_delay)) begin
               fire         = 1'b1;
               repeating_in = 1'b1;
            end
            if (fire) begin
               last_fire_in = item.time_ms;
               direction    = item.cls;
            end
            held_in = 1'b1;
         end else begin
            // Release clears the channel.
            held_in      = 1'b0;
            repeating_in = 1'b0;
            last_fire_in = '0;
         end
      end
   end

   // Channel flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            held_ff[i]      <= 1'b0;
            repeating_ff[i] <= 1'b0;
         end
      end else if (pop && state_wr) begin
         held_ff[idx]      <= held_in;
         repeating_ff[idx] <= repeating_in;
      end
   end

   // Channel timestamps; only read after a press has written them.
   always_ff @(posedge clock) begin
      if (pop && state_wr) begin
         last_fire_ff[idx] <= last_fire_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_ready) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_channel_ff   <= item.channel;
         rsp_fire_ff      <= fire;
         rsp_direction_ff <= direction;
         rsp_raw_level_ff <= raw_level;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_fire        = rsp_fire_ff;
   assign rsp_direction   = rsp_direction_ff;
   assign rsp_raw_level   = rsp_raw_level_ff;

   `IARQ_ASSERT_IMPLY(a_dir_only_in_menu, clock, reset, rsp_valid_ff && rsp_direction_ff != DIR_NONE, rsp_fire_ff && rsp_raw_level_ff == '0, "direction without a menu firing")
   `IARQ_ASSERT_IMPLY(a_out_of_range_quiet, clock, reset, rsp_valid_ff && CMP_W'(rsp_channel_ff) >= CMP_W'(NUM_CHANNELS), !rsp_fire_ff && rsp_raw_level_ff == '0 && rsp_direction_ff == DIR_NONE, "out of range channel reported activity")
   `IARQ_ASSERT_NEXT(a_release_silent, clock, reset, pop && item.in_range && item.menu_mode && !item.active, rsp_valid_ff && !rsp_fire_ff, "released channel fired")

endmodule

>>> design/input_auto_repeat_qualifier.sv
// An accepted item is written into a queue entry; when the back end pops it, its result
// is registered in the result register that drives rsp_valid and the outputs.
// Throughput: one item per cycle while rsp_ready is high; a held result stalls the queue.
// The front classifies into a two-entry queue; the back end updates state and registers.
// Reset (synchronous): clears all channel held and repeating flags, the queue and result
// valid, and restores repeat delay 500, period 100 and deadzone 8000.
`timescale 1ns / 1ps

module input_auto_repeat_qualifier import iarq_pkg::*; #(
   parameter int NUM_BUTTONS  = 15,
   parameter int NUM_CHANNELS = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHANNEL_W-1:0]       req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [TIME_W-1:0]          req_time_ms,
   input  logic                       req_menu_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CHANNEL_W-1:0]       rsp_out_channel,
   output logic                       rsp_fire,
   output logic [1:0]                 rsp_direction,
   output logic signed [SAMPLE_W-1:0] rsp_raw_level,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic [PERIOD_W-1:0]   hold_delay_ff;
   logic [PERIOD_W-1:0]   repeat_period_ff;
   logic [DEADZONE_W-1:0] dead_band_ff;
   timing_type            timing;
   item_type              front_item;
   item_type              back_item;
   logic                  back_valid;
   logic                  back_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_delay_ff    <= HOLD_DELAY_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
         dead_band_ff     <= DEAD_BAND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD_DELAY:    hold_delay_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_REPEAT_PERIOD: repeat_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_DEAD_BAND:     dead_band_ff     <= csr_wdata[DEADZONE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign timing.hold_delay    = hold_delay_ff;
   assign timing.repeat_period = repeat_period_ff;

   // Classification of the incoming item.
   iarq_front #(
      .NUM_BUTTONS  (NUM_BUTTONS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_channel   (req_channel),
      .req_sample    (req_sample),
      .req_time_ms   (req_time_ms),
      .req_menu_mode (req_menu_mode),
      .dead_band     (dead_band_ff),
      .item          (front_item)
   );

   // Queue decoupling the front and the back end.
   iarq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // Repeat state and result register.
   iarq_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (back_valid),
      .item_ready      (back_ready),
      .item            (back_item),
      .timing          (timing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_fire        (rsp_fire),
      .rsp_direction   (rsp_direction),
      .rsp_raw_level   (rsp_raw_level)
   );

endmodule

>>> tb/input_auto_repeat_qualifier_tb.sv
// Self-checking testbench for the controller auto-repeat qualifier: queue-fed driver,
// clocked monitor and a predictor that tracks per-channel hold and repeat timing.
// Depends on iarq_pkg and the input_auto_repeat_qualifier module only.
`timescale 1ns / 1ps

module input_auto_repeat_qualifier_tb;
   import iarq_pkg::*;

   localparam int NUM_BUTTONS  = 15;
   localparam int NUM_CHANNELS = 21;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 4;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   // Index past the register list; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // One polled channel sample as offered to the block.
   typedef struct packed {
      logic [CHANNEL_W-1:0]       channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          time_ms;
      logic                       menu_mode;
   } poll_type;

   // The qualified report expected back for one item.
   typedef struct packed {
      logic [CHANNEL_W-1:0]       channel;
      logic                       fire;
      dir_type                    direction;
      logic signed [SAMPLE_W-1:0] raw_level;
   } report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CHANNEL_W-1:0]       req_channel = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [TIME_W-1:0]          req_time_ms = '0;
   logic                       req_menu_mode = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [CHANNEL_W-1:0]       rsp_out_channel;
   logic                       rsp_fire;
   logic [1:0]                 rsp_direction;
   logic signed [SAMPLE_W-1:0] rsp_raw_level;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Predictor copy of the configuration and per-channel state.
   logic [PERIOD_W-1:0]   delay_cfg;
   logic [PERIOD_W-1:0]   period_cfg;
   logic [DEADZONE_W-1:0] deadzone_cfg;
   logic                  held_flag [NUM_CHANNELS];
   logic                  repeat_flag [NUM_CHANNELS];
   logic [TIME_W-1:0]     last_fire_ms [NUM_CHANNELS];
   dir_type               held_dir [NUM_CHANNELS];

   poll_type   pending_polls[$];
   report_type expected_reports[$];
   poll_type   offered_poll;
   report_type want_report;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          polls_queued = 0;
   int          reports_matched = 0;
   int          fail_count = 0;
   int          hold_left = 0;
   logic        hold_arm = 1'b0;
   logic [TIME_W-1:0] poll_clock_ms = '0;

   input_auto_repeat_qualifier #(
      .NUM_BUTTONS  (NUM_BUTTONS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_time_ms     (req_time_ms),
      .req_menu_mode   (req_menu_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_fire        (rsp_fire),
      .rsp_direction   (rsp_direction),
      .rsp_raw_level   (rsp_raw_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Work out the report for one accepted item and advance the channel's state.
   function automatic report_type predict_repeat(input poll_type poll);
      report_type res;
      dir_type      cls;
      logic [TIME_W-1:0] elapsed;
      logic         active;
      int           ch;
      int           dz;
      int           level;
      res.channel   = poll.channel;
      res.fire      = 1'b0;
      res.direction = DIR_NONE;
      res.raw_level = '0;
      ch    = poll.channel;
      dz    = deadzone_cfg;
      level = poll.sample;
      cls   = DIR_NONE;
      if (ch >= NUM_BUTTONS) begin
         if (level > dz)
            cls = DIR_POS;
         else if (level < -dz)
            cls = DIR_NEG;
      end
      if (ch < NUM_CHANNELS) begin
         if (!poll.menu_mode) begin
            // Pass-through restarts the channel's timer at the current time.
            res.fire         = (poll.sample != 0);
            res.raw_level    = poll.sample;
            held_flag[ch]    = res.fire;
            repeat_flag[ch]  = 1'b0;
            last_fire_ms[ch] = poll.time_ms;
            held_dir[ch]     = cls;
         end else begin
            active = (ch >= NUM_BUTTONS) ? (cls != DIR_NONE) : (poll.sample != 0);
            if (active) begin
               elapsed = poll.time_ms - last_fire_ms[ch];
               if (!held_flag[ch]) begin
                  res.fire        = 1'b1;
                  repeat_flag[ch] = 1'b0;
               end else if (repeat_flag[ch]) begin
                  res.fire = (elapsed >= TIME_W'(period_cfg));
               end else if (elapsed >= TIME_W'(delay_cfg)) begin
                  res.fire        = 1'b1;
                  repeat_flag[ch] = 1'b1;
               end
               if (res.fire) begin
                  last_fire_ms[ch] = poll.time_ms;
                  res.direction    = cls;
               end
               held_flag[ch] = 1'b1;
               held_dir[ch]  = cls;
            end else begin
               held_flag[ch]    = 1'b0;
               repeat_flag[ch]  = 1'b0;
               last_fire_ms[ch] = '0;
               held_dir[ch]     = DIR_NONE;
            end
         end
      end
      return res;
   endfunction

   // A sample that counts as pressed on this channel under the current deadzone.
   function automatic logic signed [SAMPLE_W-1:0] pressed_sample(input int ch);
      int dz;
      int value;
      dz = deadzone_cfg;
      if (ch < NUM_BUTTONS)
         value = ($urandom_range(0, 3) == 0) ? 1 : int'($urandom_range(1, 65535));
      else if (dz < 32767 && $urandom_range(0, 1) == 1)
         value = $urandom_range(dz + 1, 32767);
      else
         value = -int'($urandom_range(dz + 1, 32768));
      return SAMPLE_W'(value);
   endfunction

   // A sample that counts as released: zero for a button, inside the deadzone for an axis.
   function automatic logic signed [SAMPLE_W-1:0] released_sample(input int ch);
      int dz;
      int value;
      dz    = deadzone_cfg;
      value = (ch < NUM_BUTTONS) ? 0 : int'($urandom_range(0, 2 * dz)) - dz;
      return SAMPLE_W'(value);
   endfunction

   task automatic queue_poll(input int ch, input int sample, input logic [TIME_W-1:0] t,
                             input logic menu);
      poll_type poll;
      poll.channel   = CHANNEL_W'(ch);
      poll.sample    = SAMPLE_W'(sample);
      poll.time_ms   = t;
      poll.menu_mode = menu;
      pending_polls.push_back(poll);
      polls_queued++;
   endtask

   // Press, hold across the repeat timing, then usually release one channel.
   task automatic queue_hold_episode();
      int ch;
      int polls;
      int step_max;
      ch       = $urandom_range(0, NUM_CHANNELS - 1);
      polls    = $urandom_range(2, 12);
      step_max = int'(delay_cfg) / 2 + int'(period_cfg) + 2;
      for (int i = 0; i < polls; i++) begin
         poll_clock_ms += $urandom_range(0, step_max);
         queue_poll(ch, pressed_sample(ch), poll_clock_ms, $urandom_range(0, 9) != 0);
      end
      if ($urandom_range(0, 3) != 0) begin
         poll_clock_ms += $urandom_range(0, step_max);
         queue_poll(ch, released_sample(ch), poll_clock_ms, 1'b1);
      end
   endtask

   // Any channel code, any sample, any time.
   task automatic queue_noise_poll();
      logic [TIME_W-1:0] t;
      if ($urandom_range(0, 1) == 1) begin
         t = $urandom;
      end else begin
         poll_clock_ms += $urandom_range(0, 1000);
         t = poll_clock_ms;
      end
      queue_poll($urandom_range(0, 31), $urandom, t, $urandom_range(0, 1) == 1);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_HOLD_DELAY:    delay_cfg    = value;
         CSR_REPEAT_PERIOD: period_cfg   = value;
         CSR_DEAD_BAND:     deadzone_cfg = value[DEADZONE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_timing(input logic [CSR_DATA_W-1:0] delay,
                             input logic [CSR_DATA_W-1:0] period,
                             input logic [CSR_DATA_W-1:0] deadzone);
      write_csr(CSR_HOLD_DELAY, delay);
      write_csr(CSR_REPEAT_PERIOD, period);
      write_csr(CSR_DEAD_BAND, deadzone);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
   endtask

   // Wait until every queued item has been reported, then let the pipeline settle.
   task automatic wait_idle();
      while (reports_matched != polls_queued)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int send_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      target = polls_queued + count;
      while (polls_queued < target) begin
         if ($urandom_range(0, 99) < 80)
            queue_hold_episode();
         else
            queue_noise_poll();
      end
      wait_idle();
   endtask

   // Driver: predict each accepted item, then offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_reports.push_back(predict_repeat(offered_poll));
         if (!req_valid || req_ready) begin
            if (pending_polls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_poll   = pending_polls.pop_front();
               req_channel   <= offered_poll.channel;
               req_sample    <= offered_poll.sample;
               req_time_ms   <= offered_poll.time_ms;
               req_menu_mode <= offered_poll.menu_mode;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once to back the block up into its input.
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_arm)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Monitor: compare each accepted report with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report with no item pending: out_channel %0d", rsp_out_channel);
               fail_count++;
            end else begin
               want_report = expected_reports.pop_front();
               reports_matched++;
               if (rsp_out_channel !== want_report.channel) begin
                  $error("out_channel mismatch: expected %0d, got %0d",
                         want_report.channel, rsp_out_channel);
                  fail_count++;
               end
               if (rsp_fire !== want_report.fire) begin
                  $error("fire mismatch: expected %0d, got %0d", want_report.fire, rsp_fire);
                  fail_count++;
               end
               if (rsp_direction !== want_report.direction) begin
                  $error("direction mismatch: expected %0d, got %0d",
                         want_report.direction, rsp_direction);
                  fail_count++;
               end
               if (rsp_raw_level !== want_report.raw_level) begin
                  $error("raw_level mismatch: expected %0d, got %0d",
                         want_report.raw_level, rsp_raw_level);
                  fail_count++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      int pressure_target;
      delay_cfg    = HOLD_DELAY_RESET;
      period_cfg   = REPEAT_PERIOD_RESET;
      deadzone_cfg = DEAD_BAND_RESET;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         held_flag[ch]    = 1'b0;
         repeat_flag[ch]  = 1'b0;
         last_fire_ms[ch] = '0;
         held_dir[ch]     = DIR_NONE;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset timing (delay 500, period 100, deadzone 8000).
      // Button: first press, just short of the delay, at the delay, just short of one period, one period, release.
      queue_poll(0, 1, 32'd1000, 1'b1);
      queue_poll(0, 1, 32'd1499, 1'b1);
      queue_poll(0, 1, 32'd1500, 1'b1);
      queue_poll(0, 1, 32'd1599, 1'b1);
      queue_poll(0, 1, 32'd1600, 1'b1);
      queue_poll(0, 0, 32'd1700, 1'b1);
      // Any nonzero level presses a button, including the most negative one.
      queue_poll(14, -32768, 32'd1800, 1'b1);
      // Axis just past the deadzone, then a direction change while held.
      queue_poll(15, 8001, 32'd2000, 1'b1);
      queue_poll(15, -32768, 32'd2100, 1'b1);
      queue_poll(15, -9000, 32'd2500, 1'b1);
      // Axis exactly on the deadzone edge stays inactive on both sides.
      queue_poll(20, 8000, 32'd2600, 1'b1);
      queue_poll(17, -8000, 32'd2600, 1'b1);
      queue_poll(20, -8001, 32'd2700, 1'b1);
      // Pass-through arms the timer, so a menu item one delay later repeats.
      queue_poll(16, 32767, 32'd3000, 1'b0);
      queue_poll(16, 32767, 32'd3500, 1'b1);
      queue_poll(3, 0, 32'd3600, 1'b0);
      queue_poll(18, 0, 32'd3600, 1'b0);
      // Channels past the last axis report nothing.
      queue_poll(21, 5, 32'd3700, 1'b0);
      queue_poll(31, -1, 32'hFFFF_FFFF, 1'b1);
      // Held button across the time wrap.
      queue_poll(5, 1, 32'hFFFF_FF00, 1'b1);
      queue_poll(5, 1, 32'h0000_0100, 1'b1);
      queue_poll(5, -32768, 32'hFFFF_FFFF, 1'b0);
      poll_clock_ms = 32'd10000;
      wait_idle();

      // Random phases across timing settings and idling patterns.
      set_timing(16'd500, 16'd100, 16'd8000);
      run_random_phase(0, 0, 80);
      set_timing(16'd0, 16'd0, 16'd0);
      run_random_phase(69, 0, 80);
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      poll_clock_ms = 32'hFFFE_0000;
      run_random_phase(0, 69, 80);
      set_timing(CSR_DATA_W'($urandom_range(1, 2000)), CSR_DATA_W'($urandom_range(1, 500)),
                 CSR_DATA_W'($urandom_range(0, 32767)));
      run_random_phase(23, 23, 80);

      // Receiver holds off while the sender keeps offering, filling the block.
      set_timing(16'd40, 16'd10, 16'd1000);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      pressure_target = polls_queued + 40;
      while (polls_queued < pressure_target)
         queue_hold_episode();
      wait_idle();

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
